// ===== rtl/core/glyph_framebuffer_renderer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// glyph framebuffer renderer assertion macros
// shared property forms for the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef GLYPH_FRAMEBUFFER_RENDERER_UNIT_ASSERT_SVH
`define GLYPH_FRAMEBUFFER_RENDERER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gfr_pkg.sv =====
// ----------------------------------------------------------------------------
// gfr_pkg
// constants, types and the 5x7 font for the glyph framebuffer renderer
// ----------------------------------------------------------------------------
package gfr_pkg;

  // display geometry
  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;

  // field widths
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;

  localparam int STORE_DEPTH = 1 << ADDR_W;

  // page index is signed, one more than y >>> 3 can reach after +1
  localparam int PG_W  = Y_W - 2;
  localparam int ROW_W = PG_W + 2;
  localparam int IDX_W = X_W + PG_W;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int COL_W      = 3;

  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CODE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] FONT_FIRST   = 8'h20;
  localparam logic [CODE_W-1:0] FONT_LAST    = 8'h5f;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_READ_RD,
    ST_READ_OUT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_DRAW,
    ADDR_BYTE,
    ADDR_CLEAR
  } addr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      single;
    logic      mem_rd;
    logic      mem_wr;
    logic      clr_wr;
    logic      step;
    logic      out_load;
    addr_sel_t addr_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic half;
    logic col_last;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

  // column 0 sits in the top byte
  typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

  localparam glyph_t QMARK = 40'h0201510906;

  localparam glyph_t FONT_ROM [64] = '{
    40'h0000000000, 40'h00005f0000, QMARK,          QMARK,
    QMARK,          QMARK,          QMARK,          QMARK,
    QMARK,          QMARK,          QMARK,          QMARK,
    QMARK,          40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, QMARK,
    40'h0814224100, QMARK,          40'h4122140800, QMARK,
    QMARK,          40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, QMARK,
    QMARK,          QMARK,          QMARK,          40'h4040404040
  };

  // lowercase folds to uppercase, anything outside the font is a question mark
  function automatic glyph_t glyph_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    logic [5:0]        slot;
    c = code;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      c = c - (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    slot = c[5:0] - FONT_FIRST[5:0];
    if (c >= FONT_FIRST && c <= FONT_LAST) begin
      return FONT_ROM[slot];
    end
    return QMARK;
  endfunction

endpackage

// ===== rtl/core/gfr_datapath.sv =====
// ----------------------------------------------------------------------------
// gfr_datapath
// frame store, item registers, column walker, clipping and result register
// ----------------------------------------------------------------------------
`include "glyph_framebuffer_renderer_unit_assert.svh"

module gfr_datapath import gfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic [X_W-1:0]    x_pos,
  input  logic [Y_W-1:0]    y_pos,
  input  logic [CODE_W-1:0] char_code,
  input  logic              pixel_on,
  input  logic [ADDR_W-1:0] byte_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data
);

  logic [DATA_W-1:0] frame_mem [STORE_DEPTH];

  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;
  logic              on_r;
  logic [ADDR_W-1:0] byte_r;
  glyph_t            glyph_r;
  logic [COL_W-1:0]  col_r;
  logic              half_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic [X_W:0]      px;
  logic              col_ok;
  logic [PG_W-1:0]   page;
  logic              page_ok;
  logic [7:0]        row_mask;
  logic [IDX_W-1:0]  idx;
  logic              idx_ok;
  logic [6:0]        pattern;
  logic [15:0]       shifted;
  logic [7:0]        bits;
  logic [7:0]        wmask;
  logic              draw_ok;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= x_pos;
      y_r    <= y_pos;
      on_r   <= pixel_on | ~cmd.single;
      byte_r <= byte_index;
      if (cmd.single) begin
        glyph_r <= {8'h01, {((GLYPH_COLS-1)*8){1'b0}}};
      end else begin
        glyph_r <= glyph_of(char_code);
      end
    end
  end

  // column / page-half walker and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      half_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        col_r  <= '0;
        half_r <= 1'b0;
      end else if (cmd.step) begin
        half_r <= ~half_r;
        if (half_r) begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // target byte of the current column and half
  always_comb begin
    px      = {x_r[X_W-1], x_r} + {{(X_W+1-COL_W){1'b0}}, col_r};
    col_ok  = !px[X_W] && ({1'b0, px[X_W-1:0]} < (X_W+1)'(DISPLAY_WIDTH));
    page    = {y_r[Y_W-1], y_r[Y_W-1:3]} + {{(PG_W-1){1'b0}}, half_r};
    for (int n = 0; n < 8; n++) begin
      row_mask[n] = ({1'b0, page[PG_W-2:0], 3'(n)} < (ROW_W+1)'(DISPLAY_HEIGHT));
    end
    page_ok = !page[PG_W-1] && row_mask[0];
    idx     = IDX_W'(px[X_W-1:0]) + IDX_W'(page[PG_W-2:0]) * IDX_W'(DISPLAY_WIDTH);
    idx_ok  = idx < IDX_W'(STORE_DEPTH);
    pattern = glyph_r[COL_W'(GLYPH_COLS-1) - col_r][GLYPH_ROWS-1:0];
    shifted = {9'b0, pattern} << y_r[2:0];
    bits    = half_r ? shifted[15:8] : shifted[7:0];
    wmask   = bits & row_mask;
    draw_ok = col_ok && page_ok && idx_ok;
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_DRAW:  mem_addr = idx[ADDR_W-1:0];
      ADDR_BYTE:  mem_addr = byte_r;
      ADDR_CLEAR: mem_addr = clr_cnt_r;
      default:    mem_addr = byte_r;
    endcase
    mem_we    = cmd.clr_wr | (cmd.mem_wr & draw_ok);
    mem_wdata = cmd.clr_wr ? '0 : (on_r ? (rd_data_r | wmask) : (rd_data_r & ~wmask));
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= frame_mem[mem_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= rd_data_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  assign status.half     = half_r;
  assign status.col_last = (col_r == COL_W'(GLYPH_COLS-1));
  assign status.clr_last = (clr_cnt_r == ADDR_W'(STORE_DEPTH-1));
  assign status.out_busy = out_valid_r & ~out_ready;

  `GFR_ASSERT_SAME(a_no_result_overwrite, cmd.out_load, !status.out_busy,
    "result register loaded while a request still waits")
  `GFR_ASSERT_NEXT(a_result_loaded, cmd.out_load,
    out_valid_r && (out_data_r == $past(rd_data_r)), "result not presented")
  `GFR_ASSERT_SAME(a_clear_excl, cmd.clr_wr, !cmd.mem_wr && !cmd.mem_rd,
    "clear sweep overlaps a draw access")
  `GFR_ASSERT_SAME(a_clr_cnt_moves, clr_cnt_r != '0, $past(cmd.clr_wr) || !$stable(clr_cnt_r)
    || $past(clr_cnt_r) != '0, "clear counter moved outside a sweep")

endmodule

// ===== rtl/core/gfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gfr_ctrl
// sequencer for clear sweeps, read-modify-write drawing and byte reads
// ----------------------------------------------------------------------------
`include "glyph_framebuffer_renderer_unit_assert.svh"

module gfr_ctrl import gfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   single_r, single_nxt;
  cmd_code_t code;

  assign code = cmd_code_t'(in_command);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      single_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      single_r <= single_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    single_nxt   = single_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = ADDR_DRAW;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.addr_sel = ADDR_CLEAR;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.single = (code == CMD_PIXEL);
          single_nxt = (code == CMD_PIXEL);
          unique case (code)
            CMD_CLEAR:           state_nxt = ST_CLEAR;
            CMD_PIXEL, CMD_CHAR: state_nxt = ST_DRAW_RD;
            CMD_READ:            state_nxt = ST_READ_RD;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        cmd.mem_wr = 1'b1;
        if (status.half && (single_r || status.col_last)) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_DRAW_RD;
        end
      end
      ST_READ_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = ADDR_BYTE;
        state_nxt    = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        cmd.addr_sel = ADDR_BYTE;
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `GFR_ASSERT_SAME(a_write_after_read, state_r == ST_DRAW_WR,
    $past(state_r) == ST_DRAW_RD, "draw write without its read")
  `GFR_ASSERT_NEXT(a_sweep_holds, (state_r == ST_CLEAR) && !status.clr_last,
    state_r == ST_CLEAR, "clear sweep left early")
  `GFR_ASSERT_SAME(a_ready_only_idle, in_ready, state_r == ST_IDLE,
    "request taken outside idle")

endmodule

// ===== rtl/core/glyph_framebuffer_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_framebuffer_renderer_unit
// 128x64 page-major monochrome framebuffer with 5x7 character drawing
// ----------------------------------------------------------------------------
//
//   channel  ports                                   moves
//   -------  --------------------------------------  ----------------------
//   in       in_valid / in_ready + command fields    one command request
//   out      out_valid / out_ready + out_read_data   one byte per read
//
// one request at a time; in_ready is high only while the sequencer is idle
// cycles per request: pixel 5 (one column x 2 page bytes), character 21
//   (5 columns x 2 page bytes), each byte a read then a write on the single
//   frame store port; read 3 or more; clear 1025 (one byte written per cycle)
// after reset the store is swept to zero for 1024 cycles before in_ready rises
// a read result waits in its own register; a stalled out side only holds a
//   later read, never a draw or clear
//
module glyph_framebuffer_renderer_unit import gfr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic signed [X_W-1:0]    in_x_pos,
  input  logic signed [Y_W-1:0]    in_y_pos,
  input  logic [CODE_W-1:0]        in_char_code,
  input  logic                     in_pixel_on,
  input  logic [ADDR_W-1:0]        in_byte_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_read_data
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: clear sweep, per-byte read-modify-write, read return
  gfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: frame store, clipping, glyph columns and result register
  gfr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .x_pos         (in_x_pos),
    .y_pos         (in_y_pos),
    .char_code     (in_char_code),
    .pixel_on      (in_pixel_on),
    .byte_index    (in_byte_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data)
  );

endmodule
